// ===== rtl/ufr_pkg.sv =====
// Shared types and constants for the motor frame receiver.
package ufr_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    // Item kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Configuration register indexes
    localparam logic CFG_HEAD    = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    // Configuration reset values
    localparam logic [7:0]  HEAD_RST    = 8'd165;
    localparam logic [15:0] TIMEOUT_RST = 16'd50;

    // Shortest legal frame
    localparam logic [7:0] MIN_LEN = 8'd5;

    // Frame payload codes
    localparam logic [7:0] IDX_ONE  = 8'h01;
    localparam logic [7:0] IDX_TWO  = 8'h02;
    localparam logic [7:0] CMD_STOP = 8'h00;
    localparam logic [7:0] CMD_FWD  = 8'h01;
    localparam logic [7:0] CMD_REV  = 8'h02;

    // Motor state codes
    localparam logic [1:0] MOT_STOP = 2'd0;
    localparam logic [1:0] MOT_FWD  = 2'd1;
    localparam logic [1:0] MOT_REV  = 2'd2;

    // Parser events for one item
    typedef struct packed {
        logic       ok;
        logic       cerr;
        logic       lerr;
        logic       tmo;
        logic [7:0] index;
        logic [7:0] command;
    } t_frame_evt;

    // Motor and light levels after one item
    typedef struct packed {
        logic [1:0] motor_one;
        logic [1:0] motor_two;
        logic       left_light;
        logic       right_light;
        logic       power;
    } t_motor_out;

endpackage

// ===== rtl/ufr_parser.sv =====
// Frame parser: head, length, body, checksum and receive timeout.
module ufr_parser #(
    parameter int FRAME_MAX = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_req_type,
    input  logic [7:0]            i_rx_byte,
    input  logic [7:0]            i_head_byte,
    input  logic [15:0]           i_timeout_ticks,
    output ufr_pkg::t_frame_evt   o_evt
);
    import ufr_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(FRAME_MAX);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [3:0]  r_exp, n_exp;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_index, n_index;
    logic [7:0]  r_command, n_command;
    logic        r_armed, n_armed;
    logic [15:0] r_idle, n_idle;

    logic is_tick;
    logic tmo_hit;
    logic head_hit;
    logic len_bad;
    logic body_last;

    assign is_tick   = (i_req_type == REQ_TICK);
    assign tmo_hit   = (r_idle >= i_timeout_ticks);
    assign head_hit  = (i_rx_byte == i_head_byte);
    assign len_bad   = (i_rx_byte < MIN_LEN) || (i_rx_byte > MAX_LEN);
    assign body_last = (({1'b0, r_cnt} + 5'd1) >= {1'b0, r_exp});

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            if (is_tick) begin
                if (r_armed && tmo_hit) begin
                    n_phase = PH_IDLE;
                end
            end else begin
                case (r_phase)
                    PH_IDLE: if (head_hit) n_phase = PH_LEN;
                    PH_LEN:  n_phase = len_bad ? PH_IDLE : PH_BODY;
                    PH_BODY: if (body_last) n_phase = PH_IDLE;
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // Counters, checksum, captured fields and events
    always_comb begin
        n_cnt     = r_cnt;
        n_exp     = r_exp;
        n_sum     = r_sum;
        n_index   = r_index;
        n_command = r_command;
        n_armed   = r_armed;
        n_idle    = r_idle;
        o_evt         = '0;
        o_evt.index   = r_index;
        o_evt.command = r_command;
        if (i_step) begin
            if (is_tick) begin
                if (r_armed) begin
                    if (tmo_hit) begin
                        n_armed   = 1'b0;
                        o_evt.tmo = 1'b1;
                    end else begin
                        n_idle = r_idle + 16'd1;
                    end
                end
            end else begin
                n_armed = 1'b1;
                n_idle  = '0;
                case (r_phase)
                    PH_IDLE: begin
                        if (head_hit) begin
                            n_sum = i_rx_byte;
                            n_cnt = 4'd1;
                        end else begin
                            n_armed = 1'b0;
                        end
                    end
                    PH_LEN: begin
                        if (len_bad) begin
                            o_evt.lerr = 1'b1;
                            n_armed    = 1'b0;
                        end else begin
                            n_exp = i_rx_byte[3:0];
                            n_sum = r_sum + i_rx_byte;
                            n_cnt = 4'd2;
                        end
                    end
                    PH_BODY: begin
                        if (body_last) begin
                            o_evt.ok   = (i_rx_byte == r_sum);
                            o_evt.cerr = (i_rx_byte != r_sum);
                            n_armed    = 1'b0;
                        end else begin
                            if (r_cnt == 4'd2) n_index = i_rx_byte;
                            if (r_cnt == 4'd3) n_command = i_rx_byte;
                            n_sum = r_sum + i_rx_byte;
                            n_cnt = r_cnt + 4'd1;
                        end
                    end
                    default: n_armed = 1'b0;
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_exp     <= '0;
            r_sum     <= '0;
            r_index   <= '0;
            r_command <= '0;
            r_armed   <= 1'b0;
            r_idle    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_exp     <= n_exp;
            r_sum     <= n_sum;
            r_index   <= n_index;
            r_command <= n_command;
            r_armed   <= n_armed;
            r_idle    <= n_idle;
        end
    end

endmodule

// ===== rtl/ufr_motor.sv =====
// Motor, light and light power state updated by good frames.
module ufr_motor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  ufr_pkg::t_frame_evt  i_evt,
    output ufr_pkg::t_motor_out  o_next
);
    import ufr_pkg::*;

    t_motor_out r_st, n_st;

    // Apply a good frame, then the power pin rule
    always_comb begin
        n_st = r_st;
        if (i_step && i_evt.ok) begin
            if (i_evt.index == IDX_ONE) begin
                case (i_evt.command)
                    CMD_STOP: n_st.motor_one = MOT_STOP;
                    CMD_FWD: begin
                        n_st.motor_one  = MOT_FWD;
                        n_st.left_light = 1'b1;
                    end
                    CMD_REV: begin
                        n_st.motor_one  = MOT_REV;
                        n_st.left_light = 1'b0;
                    end
                    default: n_st.motor_one = r_st.motor_one;
                endcase
            end else if (i_evt.index == IDX_TWO) begin
                case (i_evt.command)
                    CMD_STOP: n_st.motor_two = MOT_STOP;
                    CMD_FWD: begin
                        n_st.motor_two   = MOT_FWD;
                        n_st.right_light = 1'b1;
                    end
                    CMD_REV: begin
                        n_st.motor_two   = MOT_REV;
                        n_st.right_light = 1'b0;
                    end
                    default: n_st.motor_two = r_st.motor_two;
                endcase
            end
            if (n_st.motor_one == MOT_REV && n_st.motor_two == MOT_REV) begin
                n_st.power = 1'b0;
            end else if (n_st.motor_one == MOT_FWD || n_st.motor_two == MOT_FWD) begin
                n_st.power = 1'b1;
            end
        end
    end

    assign o_next = n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

endmodule

// ===== rtl/uart_motor_frame_receiver.sv =====
// Top level of the motor command frame receiver.
// Path: input register, one step of parser and motor logic, then the result
// register, which holds while the output is stalled.
// Throughput: one item per cycle while the output channel is not stalled.
// Reset (synchronous, active low): parser idle, timer disarmed, motors stopped,
// lights and power off, head byte 165, timeout 50 ticks, both channels empty.
module uart_motor_frame_receiver #(
    parameter int FRAME_MAX = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_rx_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_frame_ok,
    output logic        o_checksum_error,
    output logic        o_length_error,
    output logic        o_timed_out,
    output logic [1:0]  o_motor_one_state,
    output logic [1:0]  o_motor_two_state,
    output logic        o_left_light_on,
    output logic        o_right_light_on,
    output logic        o_light_power_on
);
    import ufr_pkg::*;

    logic [7:0]  r_head_byte;
    logic [15:0] r_timeout;
    logic        r_in_valid;
    logic        r_in_type;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic [3:0]  r_flags;
    t_motor_out  r_motor;

    logic       step;
    t_frame_evt evt;
    t_motor_out motor_next;

    // Advance when the input register holds an item and the result slot frees
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_byte <= HEAD_RST;
            r_timeout   <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEAD:    r_head_byte <= i_cfg_data[7:0];
                CFG_TIMEOUT: r_timeout   <= i_cfg_data;
                default:     r_head_byte <= r_head_byte;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_type <= i_req_type;
            r_in_byte <= i_rx_byte;
        end
    end

    ufr_parser #(
        .FRAME_MAX (FRAME_MAX)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_req_type      (r_in_type),
        .i_rx_byte       (r_in_byte),
        .i_head_byte     (r_head_byte),
        .i_timeout_ticks (r_timeout),
        .o_evt           (evt)
    );

    ufr_motor u_motor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_evt   (evt),
        .o_next  (motor_next)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_flags <= {evt.ok, evt.cerr, evt.lerr, evt.tmo};
            r_motor <= motor_next;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_frame_ok        = r_flags[3];
    assign o_checksum_error  = r_flags[2];
    assign o_length_error    = r_flags[1];
    assign o_timed_out       = r_flags[0];
    assign o_motor_one_state = r_motor.motor_one;
    assign o_motor_two_state = r_motor.motor_two;
    assign o_left_light_on   = r_motor.left_light;
    assign o_right_light_on  = r_motor.right_light;
    assign o_light_power_on  = r_motor.power;

endmodule

// ===== rtl/ufr_checker.sv =====
// Port-level checks for the motor frame receiver, bound to the top level.
module ufr_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_frame_ok,
    input logic        o_checksum_error,
    input logic        o_length_error,
    input logic        o_timed_out,
    input logic [1:0]  o_motor_one_state,
    input logic [1:0]  o_motor_two_state,
    input logic        o_left_light_on,
    input logic        o_right_light_on,
    input logic        o_light_power_on
);
    import ufr_pkg::*;

    // A stalled result stays valid, and its frame-ok, timeout and motor-one fields hold until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_frame_ok)
            && $stable(o_timed_out) && $stable(o_motor_one_state))
        else $error("result changed while stalled");

    // At most one event flag per result
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_frame_ok, o_checksum_error, o_length_error,
                                  o_timed_out}))
        else $error("more than one event flag");

    // Motor state codes stay in range
    a_motor_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_motor_one_state <= MOT_REV) && (o_motor_two_state <= MOT_REV))
        else $error("motor state out of range");

    // A light follows its motor when running
    a_lights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_motor_one_state != MOT_FWD || o_left_light_on)
            && (o_motor_one_state != MOT_REV || !o_left_light_on)
            && (o_motor_two_state != MOT_FWD || o_right_light_on)
            && (o_motor_two_state != MOT_REV || !o_right_light_on))
        else $error("light does not match motor");

    // Power pin: off with both in reverse, on with either forward
    a_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_motor_one_state == MOT_REV && o_motor_two_state == MOT_REV)
                ? !o_light_power_on
                : ((o_motor_one_state != MOT_FWD && o_motor_two_state != MOT_FWD)
                    || o_light_power_on)))
        else $error("light power pin wrong");

endmodule

bind uart_motor_frame_receiver ufr_port_checks u_ufr_port_checks (.*);
